>>> hw/rtl/mfr_pkg.sv
package mfr_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 15;
   localparam int PAIR_W   = 16;

   // frame marker bytes
   localparam logic [BYTE_W-1:0] START_BYTE = 8'h68;
   localparam logic [BYTE_W-1:0] END_BYTE   = 8'h16;
   localparam logic [BYTE_W-1:0] FILL_BYTE  = 8'hAA;

   // length offsets and header positions
   localparam logic [COUNT_W-1:0] LEN_ADD_645     = 15'd12;
   localparam logic [COUNT_W-1:0] LEN_ADD_376     = 15'd8;
   localparam logic [COUNT_W-1:0] ADDR_FIRST_645  = 15'd1;
   localparam logic [COUNT_W-1:0] ADDR_LAST_645   = 15'd6;
   localparam logic [COUNT_W-1:0] HEAD_END_645    = 15'd7;
   localparam logic [COUNT_W-1:0] LEN_POS_645     = 15'd9;
   localparam logic [COUNT_W-1:0] LEN_LO_376      = 15'd1;
   localparam logic [COUNT_W-1:0] LEN_HI_376      = 15'd2;
   localparam logic [COUNT_W-1:0] LEN_LO_RPT_376  = 15'd3;
   localparam logic [COUNT_W-1:0] LEN_HI_RPT_376  = 15'd4;

   // protocol mode codes
   localparam logic MODE_645 = 1'b0;
   localparam logic MODE_376 = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_BUSY       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_GOOD       = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_HEADER_BAD = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_SUM_BAD    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_END_BAD    = 3'd4;

   // one result beat
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  frame_length;
      logic [BYTE_W-1:0]   checksum_value;
   } mfr_result_type;

endpackage

>>> hw/rtl/mfr_if.sv
interface mfr_req_if import mfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfr_rsp_if import mfr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  frame_length;
   logic [BYTE_W-1:0]   checksum_value;

   modport source (output valid, output status, output frame_length,
                   output checksum_value, input ready);
   modport sink   (input valid, input status, input frame_length,
                   input checksum_value, output ready);
endinterface

>>> hw/rtl/meter_frame_receiver.sv
// Byte-serial meter frame receiver. Each req beat carries one received byte and produces
// exactly one rsp beat: status 0 while hunting or inside a frame, or the verdict on the byte
// that ends a frame (1 good, 2 header bad, 3 checksum bad, 4 end byte bad), together with the
// expected frame length once known and the running checksum. One byte is taken every cycle
// while ready is high: the frame state updates in one pass of compare-and-add logic per
// byte, and a two-entry output buffer keeps req ready registered, so ready drops only
// when two results wait. protocol_mode (csr_wr_data, written with csr_wr_en) is sampled
// at each start byte; 0 selects 645 rules, 1 selects 376.1.
module meter_frame_receiver import mfr_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   mfr_req_if.sink   req_chan,
   mfr_rsp_if.source rsp_chan,
   input  logic   csr_wr_en,
   input  logic   csr_wr_data
);

   logic           req_accept;
   logic           buf_ready;
   mfr_result_type parse_result;
   mfr_result_type rsp_data;

   assign req_chan.ready = buf_ready;
   assign req_accept     = req_chan.valid && buf_ready;

   // frame decode and state
   mfr_frame_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (req_accept),
      .rx_byte     (req_chan.rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (parse_result)
   );

   // result register with skid
   mfr_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (buf_ready),
      .in_data   (parse_result),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.status         = rsp_data.status;
   assign rsp_chan.frame_length   = rsp_data.frame_length;
   assign rsp_chan.checksum_value = rsp_data.checksum_value;

   // a taken byte always shows a result next cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_chan.valid)
      else $error("accepted byte produced no result");

   // input stalls only while results are waiting
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid)
      else $error("input stalled with empty output");

   // header fault never reports a length
   a_hdr_bad_len: assert property (@(posedge clock) disable iff (reset)
      (req_accept && parse_result.status == STATUS_HEADER_BAD)
         |-> parse_result.frame_length == '0)
      else $error("header fault with nonzero length");

   // buffer comes out of reset ready
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_chan.ready)
      else $error("not ready after reset");

endmodule

>>> hw/rtl/mfr_frame_parser.sv
module mfr_frame_parser import mfr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_accept,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   output mfr_result_type    result
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEAD645,
      PH_HEAD376,
      PH_BODY
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic                 mode_ff;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   exp_len_ff, exp_len_in;
   logic [BYTE_W-1:0]    sum_ff, sum_in;
   logic [PAIR_W-1:0]    pair_ff, pair_in;
   logic [1:0]           flags_ff, flags_in;
   logic [BYTE_W-1:0]    rcv_sum_ff, rcv_sum_in;
   logic [COUNT_W:0]     pos_plus2;
   logic                 done;

   function automatic logic is_bcd(input logic [BYTE_W-1:0] b);
      return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
   endfunction

   assign pos_plus2 = {1'b0, count_ff} + 16'd2;

   // per-beat frame decode
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      exp_len_in = exp_len_ff;
      sum_in     = sum_ff;
      pair_in    = pair_ff;
      flags_in   = flags_ff;
      rcv_sum_in = rcv_sum_ff;
      done       = 1'b0;
      result.status = STATUS_BUSY;

      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == START_BYTE) begin
               flags_in   = 2'b11;
               pair_in    = '0;
               rcv_sum_in = '0;
               exp_len_in = '0;
               count_in   = 15'd1;
               if (mode_ff == MODE_645) begin
                  phase_in = PH_HEAD645;
                  sum_in   = rx_byte;
               end else begin
                  phase_in = PH_HEAD376;
                  sum_in   = '0;
               end
            end
         end
         PH_HEAD645: begin
            sum_in   = sum_ff + rx_byte;
            count_in = count_ff + 15'd1;
            if (count_ff >= ADDR_FIRST_645 && count_ff <= ADDR_LAST_645) begin
               // address must be all bcd or all fill
               if (!is_bcd(rx_byte)) flags_in[0] = 1'b0;
               if (rx_byte != FILL_BYTE) flags_in[1] = 1'b0;
            end else if (count_ff == HEAD_END_645) begin
               if (rx_byte != START_BYTE || flags_ff == 2'b00) begin
                  result.status = STATUS_HEADER_BAD;
                  done = 1'b1;
               end
            end else if (count_ff == LEN_POS_645) begin
               exp_len_in = COUNT_W'(rx_byte) + LEN_ADD_645;
               phase_in   = PH_BODY;
            end
         end
         PH_HEAD376: begin
            count_in = count_ff + 15'd1;
            if (count_ff == LEN_LO_376) begin
               pair_in[7:0] = rx_byte;
            end else if (count_ff == LEN_HI_376) begin
               pair_in[15:8] = rx_byte;
            end else if (count_ff == LEN_LO_RPT_376) begin
               if (rx_byte != pair_ff[7:0]) flags_in[0] = 1'b0;
            end else if (count_ff == LEN_HI_RPT_376) begin
               if (rx_byte != pair_ff[15:8]) flags_in[0] = 1'b0;
            end else begin
               // second start byte closes the header
               if (rx_byte != START_BYTE || !flags_ff[0]) begin
                  result.status = STATUS_HEADER_BAD;
                  done = 1'b1;
               end else begin
                  exp_len_in = COUNT_W'(pair_ff >> 2) + LEN_ADD_376;
                  phase_in   = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            count_in = count_ff + 15'd1;
            if (pos_plus2 < {1'b0, exp_len_ff}) begin
               sum_in = sum_ff + rx_byte;
            end else if (pos_plus2 == {1'b0, exp_len_ff}) begin
               rcv_sum_in = rx_byte;
            end else begin
               // trailer verdict, checksum fault wins
               priority if (rcv_sum_ff != sum_ff) begin
                  result.status = STATUS_SUM_BAD;
               end else if (rx_byte != END_BYTE) begin
                  result.status = STATUS_END_BAD;
               end else begin
                  result.status = STATUS_GOOD;
               end
               done = 1'b1;
            end
         end
      endcase

      result.frame_length   = (result.status == STATUS_HEADER_BAD) ? '0 : exp_len_in;
      result.checksum_value = sum_in;

      // back to hunting after any verdict
      if (done) begin
         phase_in   = PH_HUNT;
         count_in   = '0;
         exp_len_in = '0;
         sum_in     = '0;
         pair_in    = '0;
         flags_in   = 2'b11;
         rcv_sum_in = '0;
      end
   end

   // frame state and mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         mode_ff    <= MODE_645;
         count_ff   <= '0;
         exp_len_ff <= '0;
         sum_ff     <= '0;
         pair_ff    <= '0;
         flags_ff   <= 2'b11;
         rcv_sum_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (byte_accept) begin
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            exp_len_ff <= exp_len_in;
            sum_ff     <= sum_in;
            pair_ff    <= pair_in;
            flags_ff   <= flags_in;
            rcv_sum_ff <= rcv_sum_in;
         end
      end
   end

endmodule

>>> hw/rtl/mfr_rsp_buffer.sv
module mfr_rsp_buffer import mfr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  mfr_result_type in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output mfr_result_type out_data
);

   logic           main_valid_ff;
   logic           skid_valid_ff;
   mfr_result_type main_data_ff;
   mfr_result_type skid_data_ff;
   logic           push;
   logic           pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;

   // control: output stage plus one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (!main_valid_ff) begin
         main_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (pop && skid_valid_ff) begin
         main_data_ff <= skid_data_ff;
      end else if (push && (pop || !main_valid_ff)) begin
         main_data_ff <= in_data;
      end
      if (push && main_valid_ff && !pop) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

>>> bench/meter_frame_receiver_tb.sv
module meter_frame_receiver_tb;
   import mfr_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 60;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_BYTES   = 140;

   typedef enum logic [1:0] {HUNT, HEAD_645, HEAD_376, BODY} parse_phase_type;
   typedef enum {FRAME_OK, FAULT_HEAD, FAULT_SUM, FAULT_END, FAULT_BOTH} frame_fault_type;
   typedef enum {ADDR_DIGITS, ADDR_FILL, ADDR_MIXED} addr_kind_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   mfr_req_if req_chan();
   mfr_rsp_if rsp_chan();

   meter_frame_receiver u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // bytes waiting to be sent, the frame under construction, results still due
   logic [BYTE_W-1:0] byte_backlog[$];
   logic [BYTE_W-1:0] frame_bytes[$];
   mfr_result_type    result_due[$];

   int src_idle_pct   = 7;
   int rsp_idle_pct   = 70;
   bit req_taken      = 1'b0;
   int stall_asks     = 0;
   int stall_seen     = 0;
   int stall_left     = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   // frame parser state of the prediction
   logic               mode_now;
   parse_phase_type    parse_phase;
   logic [COUNT_W-1:0] byte_pos;
   logic [COUNT_W-1:0] length_due;
   logic [BYTE_W-1:0]  sum_acc;
   logic [PAIR_W-1:0]  length_pair;
   logic [1:0]         addr_ok;
   logic [BYTE_W-1:0]  sum_rcvd;

   function automatic void enter_hunt();
      parse_phase = HUNT;
      byte_pos    = '0;
      length_due  = '0;
      sum_acc     = '0;
      length_pair = '0;
      addr_ok     = 2'b11;
      sum_rcvd    = '0;
   endfunction

   // advance the parser by one byte and return the result it gives
   function automatic mfr_result_type frame_step(input logic [BYTE_W-1:0] b);
      mfr_result_type     r;
      logic [COUNT_W-1:0] p;
      logic               ended;
      r.status = STATUS_BUSY;
      p        = byte_pos;
      ended    = 1'b0;
      case (parse_phase)
         HUNT: begin
            if (b == START_BYTE) begin
               addr_ok     = 2'b11;
               length_pair = '0;
               sum_rcvd    = '0;
               length_due  = '0;
               byte_pos    = 15'd1;
               if (mode_now == MODE_645) begin
                  parse_phase = HEAD_645;
                  sum_acc     = b;
               end else begin
                  parse_phase = HEAD_376;
                  sum_acc     = '0;
               end
            end
         end
         HEAD_645: begin
            sum_acc = sum_acc + b;
            if (p >= ADDR_FIRST_645 && p <= ADDR_LAST_645) begin
               if (!(b[7:4] <= 4'd9 && b[3:0] <= 4'd9)) addr_ok[0] = 1'b0;
               if (b != FILL_BYTE) addr_ok[1] = 1'b0;
            end else if (p == HEAD_END_645) begin
               if (b != START_BYTE || addr_ok == 2'b00) begin
                  r.status = STATUS_HEADER_BAD;
                  ended    = 1'b1;
               end
            end else if (p == LEN_POS_645) begin
               length_due  = COUNT_W'(b) + LEN_ADD_645;
               parse_phase = BODY;
            end
            byte_pos = p + 15'd1;
         end
         HEAD_376: begin
            if (p == LEN_LO_376) begin
               length_pair[7:0] = b;
            end else if (p == LEN_HI_376) begin
               length_pair[15:8] = b;
            end else if (p == LEN_LO_RPT_376) begin
               if (b != length_pair[7:0]) addr_ok[0] = 1'b0;
            end else if (p == LEN_HI_RPT_376) begin
               if (b != length_pair[15:8]) addr_ok[0] = 1'b0;
            end else begin
               if (b != START_BYTE || !addr_ok[0]) begin
                  r.status = STATUS_HEADER_BAD;
                  ended    = 1'b1;
               end else begin
                  length_due  = COUNT_W'(length_pair[15:2]) + LEN_ADD_376;
                  parse_phase = BODY;
               end
            end
            byte_pos = p + 15'd1;
         end
         default: begin
            if (int'(p) + 2 < int'(length_due)) begin
               sum_acc = sum_acc + b;
            end else if (int'(p) + 2 == int'(length_due)) begin
               sum_rcvd = b;
            end else begin
               if (sum_rcvd != sum_acc)  r.status = STATUS_SUM_BAD;
               else if (b != END_BYTE)   r.status = STATUS_END_BAD;
               else                      r.status = STATUS_GOOD;
               ended = 1'b1;
            end
            byte_pos = p + 15'd1;
         end
      endcase
      r.frame_length   = (r.status == STATUS_HEADER_BAD) ? '0 : length_due;
      r.checksum_value = sum_acc;
      if (ended) enter_hunt();
      return r;
   endfunction

   function automatic void check_field(input string what, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   // checksum and end byte, with the requested trailer faults
   function automatic void close_frame(input int from, input frame_fault_type fault);
      logic [BYTE_W-1:0] cs;
      cs = '0;
      for (int i = from; i < frame_bytes.size(); i++) cs = cs + frame_bytes[i];
      if (fault == FAULT_SUM || fault == FAULT_BOTH) cs = cs ^ 8'($urandom_range(1, 255));
      frame_bytes.push_back(cs);
      if (fault == FAULT_END || fault == FAULT_BOTH)
         frame_bytes.push_back(END_BYTE ^ 8'($urandom_range(1, 255)));
      else
         frame_bytes.push_back(END_BYTE);
   endfunction

   // 645 frame; a header fault stops the frame at byte 7
   function automatic void build_645(input addr_kind_type kind, input int dlen,
                                     input frame_fault_type fault);
      int slot;
      slot = $urandom_range(0, 5);
      frame_bytes = {};
      frame_bytes.push_back(START_BYTE);
      for (int i = 0; i < 6; i++) begin
         if (kind == ADDR_FILL || (kind == ADDR_MIXED && i == slot))
            frame_bytes.push_back(FILL_BYTE);
         else
            frame_bytes.push_back({4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))});
      end
      if (fault == FAULT_HEAD) begin
         if (kind == ADDR_MIXED) frame_bytes.push_back(START_BYTE);
         else                    frame_bytes.push_back(START_BYTE ^ 8'($urandom_range(1, 255)));
         return;
      end
      frame_bytes.push_back(START_BYTE);
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(8'(dlen));
      for (int i = 0; i < dlen; i++) frame_bytes.push_back(8'($urandom));
      close_frame(0, fault);
   endfunction

   // 376.1 frame; a header fault stops the frame at byte 5
   function automatic void build_376(input logic [PAIR_W-1:0] pair,
                                     input frame_fault_type fault);
      int which;
      int len;
      frame_bytes = {};
      frame_bytes.push_back(START_BYTE);
      frame_bytes.push_back(pair[7:0]);
      frame_bytes.push_back(pair[15:8]);
      if (fault == FAULT_HEAD) begin
         which = $urandom_range(0, 2);
         frame_bytes.push_back(which == 0 ? pair[7:0] ^ 8'($urandom_range(1, 255)) : pair[7:0]);
         frame_bytes.push_back(which == 1 ? pair[15:8] ^ 8'($urandom_range(1, 255)) : pair[15:8]);
         frame_bytes.push_back(which == 2 ? START_BYTE ^ 8'($urandom_range(1, 255)) : START_BYTE);
         return;
      end
      frame_bytes.push_back(pair[7:0]);
      frame_bytes.push_back(pair[15:8]);
      frame_bytes.push_back(START_BYTE);
      len = int'(pair[15:2]) + 8;
      for (int i = 0; i < len - 8; i++) frame_bytes.push_back(8'($urandom));
      close_frame(6, fault);
   endfunction

   // mostly well-formed frames of the current rules, some noise and foreign frames
   function automatic void build_random_frame(input logic mode);
      int              r;
      int              pick;
      logic            rules;
      frame_fault_type fault;
      addr_kind_type   kind;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         frame_bytes = {};
         repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
         return;
      end
      rules = (r < 18) ? ~mode : mode;
      pick  = $urandom_range(0, 99);
      fault = pick < 65 ? FRAME_OK : pick < 75 ? FAULT_HEAD : pick < 85 ? FAULT_SUM :
              pick < 93 ? FAULT_END : FAULT_BOTH;
      if (rules == MODE_645) begin
         if (fault == FAULT_HEAD && $urandom_range(0, 1)) kind = ADDR_MIXED;
         else if ($urandom_range(0, 1))                   kind = ADDR_DIGITS;
         else                                             kind = ADDR_FILL;
         build_645(kind, $urandom_range(0, 99) < 4 ? $urandom_range(0, 255) :
                   $urandom_range(0, 16), fault);
      end else if (fault == FAULT_HEAD) begin
         build_376(16'($urandom_range(0, 65535)), fault);
      end else begin
         build_376(16'($urandom_range(0, 99) < 4 ? $urandom_range(0, 1023) :
                   $urandom_range(0, 63)), fault);
      end
   endfunction

   task automatic queue_bytes(input int from, input int upto);
      for (int i = from; i < upto; i++) byte_backlog.push_back(frame_bytes[i]);
   endtask

   // sender pauses until every result is back, then lets the block settle
   task automatic wait_idle();
      while (byte_backlog.size() != 0 || result_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input logic mode);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_phase(input int n, input int s_idle, input int r_idle,
                               input logic mode, input bit hold);
      int queued;
      queued = 0;
      write_mode(mode);
      @(posedge clock);
      src_idle_pct = s_idle;
      rsp_idle_pct = r_idle;
      while (queued < n) begin
         build_random_frame(mode);
         queued += frame_bytes.size();
         queue_bytes(0, frame_bytes.size());
      end
      // long receiver hold-off while the sender keeps offering
      if (hold) begin
         while (byte_backlog.size() > n / 2) @(negedge clock);
         @(posedge clock);
         stall_asks++;
      end
      wait_idle();
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // byte driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
            req_chan.valid   <= 1'b1;
            req_chan.rx_byte <= byte_backlog[0];
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result ready, with random gaps and requested hold-offs
   always @(negedge clock) begin
      if (stall_seen != stall_asks) begin
         stall_seen = stall_asks;
         stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !reset && ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // prediction on each accepted byte, check on each result beat
   always @(posedge clock) begin
      mfr_result_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("Test completed with failures");
         $finish;
      end
      if (reset) begin
         mode_now  = MODE_645;
         req_taken = 1'b0;
         enter_hunt();
      end else begin
         if (csr_wr_en) mode_now = csr_wr_data;
         req_taken = req_chan.valid && req_chan.ready;
         if (req_taken) result_due.push_back(frame_step(byte_backlog.pop_front()));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (result_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d", $time,
                        rsp_chan.status, rsp_chan.frame_length, rsp_chan.checksum_value);
               mismatch_count++;
            end else begin
               want = result_due.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_chan.status));
               check_field("frame_length", 16'(want.frame_length), 16'(rsp_chan.frame_length));
               check_field("checksum_value", 16'(want.checksum_value),
                           16'(rsp_chan.checksum_value));
            end
         end
      end
   end

   // stimulus
   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      rsp_chan.ready   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 645 rules after reset: skipped bytes, fill address, mixed address
      byte_backlog.push_back(8'h00);
      byte_backlog.push_back(8'hFF);
      byte_backlog.push_back(END_BYTE);
      build_645(ADDR_FILL, 0, FRAME_OK);
      queue_bytes(0, frame_bytes.size());
      build_645(ADDR_MIXED, 0, FAULT_HEAD);
      queue_bytes(0, frame_bytes.size());
      wait_idle();

      // 376.1 rules: shortest frame, header fault, both trailer faults
      write_mode(MODE_376);
      build_376(16'd3, FRAME_OK);
      queue_bytes(0, frame_bytes.size());
      build_376(16'hFFFF, FAULT_HEAD);
      queue_bytes(0, frame_bytes.size());
      build_376(16'd4, FAULT_BOTH);
      queue_bytes(0, frame_bytes.size());

      // mode change in the middle of a frame keeps the latched rules
      build_376(16'd8, FAULT_SUM);
      queue_bytes(0, 3);
      wait_idle();
      write_mode(MODE_645);
      queue_bytes(3, frame_bytes.size());
      wait_idle();

      // random frames under each idling pattern and both rule sets
      random_phase(PHASE_BYTES, 7, 70, MODE_645, 1'b0);
      random_phase(PHASE_BYTES, 7, 70, MODE_376, 1'b0);
      random_phase(PHASE_BYTES, 70, 7, MODE_376, 1'b0);
      random_phase(PHASE_BYTES, 70, 7, MODE_645, 1'b0);
      random_phase(PHASE_BYTES, 0, 0, MODE_645, 1'b1);
      random_phase(PHASE_BYTES, 0, 0, MODE_376, 1'b1);

      if (mismatch_count == 0 && result_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/mfr_pkg.sv
hw/rtl/mfr_if.sv
hw/rtl/mfr_frame_parser.sv
hw/rtl/mfr_rsp_buffer.sv
hw/rtl/meter_frame_receiver.sv
bench/meter_frame_receiver_tb.sv
